[sv/scpr_pkg.sv]
// Shared types and constants for the crop-and-scale pixel reader.
// Used by scpr_front, scpr_back and the top level; depends on nothing.
`default_nettype none

package scpr_pkg;

    localparam int DEFAULT_MAX_SIDE = 256;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int DEST_W     = 12;
    localparam int STEP_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = DEST_W + STEP_W;
    localparam int SRC_W      = PROD_W - FRAC_W + 1;
    localparam int OFF_W      = 8;
    localparam int SIDE_CFG_W = 9;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET    = 3'd5;

    localparam logic [SIDE_CFG_W-1:0] RST_SIDE   = 9'd256;
    localparam logic [STEP_W-1:0]     RST_STEP   = 24'd65536;
    localparam logic [OFF_W-1:0]      RST_OFFSET = 8'd0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic              is_read;
        logic [PIX_W-1:0]  pixel;    // red 23:16, green 15:8, blue 7:0
        logic [DEST_W-1:0] dest_row;
        logic [DEST_W-1:0] dest_col;
    } t_item;

endpackage

`default_nettype wire

[sv/scpr_front.sv]
// Front end: accepts input transactions, tags them as load or read and
// queues them for the back end. Depends on scpr_pkg.
`default_nettype none

module scpr_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic           i_mode,
    input  wire logic [7:0]     i_blue_in,
    input  wire logic [7:0]     i_green_in,
    input  wire logic [7:0]     i_red_in,
    input  wire logic [11:0]    i_dest_row,
    input  wire logic [11:0]    i_dest_col,
    output scpr_pkg::t_item     o_item,
    output logic                o_item_valid,
    input  wire logic           i_pop
);
    import scpr_pkg::*;

    t_item                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]    r_count, n_count;
    logic                 push;
    t_item                item_in;

    always_comb begin
        item_in.is_read  = i_mode;
        item_in.pixel    = {i_red_in, i_green_in, i_blue_in};
        item_in.dest_row = i_dest_row;
        item_in.dest_col = i_dest_col;
    end

    assign o_stall      = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_item       = r_q[r_rd_ptr];
    assign o_item_valid = (r_count != '0);

    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item_in;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[QUEUE_AW-1:0] == QUEUE_AW'(r_wr_ptr - r_rd_ptr))
        else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

[sv/scpr_back.sv]
// Back end: sequencer that writes loads into the frame store and maps reads
// to a source pixel, with the output register. Depends on scpr_pkg.
`default_nettype none

module scpr_back #(
    parameter  int MAX_SIDE = scpr_pkg::DEFAULT_MAX_SIDE,
    localparam int SW       = $clog2(MAX_SIDE + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire scpr_pkg::t_item          i_item,
    input  wire logic                     i_item_valid,
    output logic                          o_pop,
    input  wire logic [SW-1:0]            i_w_eff,
    input  wire logic [SW-1:0]            i_h_eff,
    input  wire logic [scpr_pkg::STEP_W-1:0] i_row_step,
    input  wire logic [scpr_pkg::STEP_W-1:0] i_col_step,
    input  wire logic [scpr_pkg::OFF_W-1:0]  i_row_offset,
    input  wire logic [scpr_pkg::OFF_W-1:0]  i_col_offset,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [7:0]                    o_blue_out,
    output logic [7:0]                    o_green_out,
    output logic [7:0]                    o_red_out,
    output logic                          o_outside
);
    import scpr_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = AW + 1;

    typedef enum logic [5:0] {
        S_FETCH = 6'b000001,
        S_LOAD  = 6'b000010,
        S_MUL   = 6'b000100,
        S_CHK   = 6'b001000,
        S_ADDR  = 6'b010000,
        S_READ  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_item              r_cur;
    logic [PIX_W-1:0]   r_mem [DEPTH];
    logic [PIX_W-1:0]   r_rdata;
    logic [PROD_W-1:0]  r_prod_row, r_prod_col;
    logic [SW-1:0]      r_srow, r_scol;
    logic               r_outside;
    logic [AW-1:0]      r_addr;
    logic [FW-1:0]      r_ptr, n_ptr;
    logic [FW-1:0]      r_frame;
    logic               r_out_valid, n_out_valid;
    logic               out_load;
    logic [FW-1:0]      ptr_cur, ptr_inc;
    logic [SRC_W-1:0]   srow_full, scol_full;
    logic [2*SW-1:0]    addr_full;

    assign o_pop = (r_state == S_FETCH) && i_item_valid;

    // Load pointer wraps when the frame fills or a size change leaves it beyond
    always_comb begin
        ptr_cur = (r_ptr >= r_frame) ? '0 : r_ptr;
        ptr_inc = ptr_cur + 1'b1;
        n_ptr   = r_ptr;
        if (r_state == S_LOAD) begin
            n_ptr = (ptr_inc >= r_frame) ? '0 : ptr_inc;
        end
    end

    always_comb begin
        srow_full = SRC_W'(i_row_offset) + SRC_W'(r_prod_row[PROD_W-1:FRAC_W]);
        scol_full = SRC_W'(i_col_offset) + SRC_W'(r_prod_col[PROD_W-1:FRAC_W]);
        addr_full = r_srow * i_w_eff + (2*SW)'(r_scol);
    end

    assign out_load = (r_state == S_READ) || 1'b0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FETCH: begin
                if (i_item_valid) begin
                    n_state = i_item.is_read ? S_MUL : S_LOAD;
                end
            end
            S_LOAD: n_state = S_FETCH;
            S_MUL:  n_state = S_CHK;
            S_CHK:  n_state = S_ADDR;
            S_ADDR: begin
                // wait here until the output register can take the result
                if (!r_out_valid || !i_stall) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_FETCH;
            default: n_state = S_FETCH;
        endcase
    end

    // The memory read issued in S_READ goes to r_rdata (with r_fill set), then into the output register
    logic r_fill;

    always_comb begin
        n_out_valid = r_fill ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
            r_fill      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            r_fill      <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= FW'(i_w_eff) * FW'(i_h_eff);
        if (o_pop) begin
            r_cur <= i_item;
        end
        if (r_state == S_MUL) begin
            r_prod_row <= PROD_W'(r_cur.dest_row) * PROD_W'(i_row_step);
            r_prod_col <= PROD_W'(r_cur.dest_col) * PROD_W'(i_col_step);
        end
        if (r_state == S_CHK) begin
            r_outside <= (srow_full >= SRC_W'(i_h_eff)) || (scol_full >= SRC_W'(i_w_eff));
            r_srow    <= srow_full[SW-1:0];
            r_scol    <= scol_full[SW-1:0];
        end
        if (r_state == S_ADDR) begin
            r_addr <= addr_full[AW-1:0];
        end
        if (r_fill) begin
            o_blue_out  <= r_outside ? '0 : r_rdata[CH_W-1:0];
            o_green_out <= r_outside ? '0 : r_rdata[2*CH_W-1:CH_W];
            o_red_out   <= r_outside ? '0 : r_rdata[PIX_W-1:2*CH_W];
            o_outside   <= r_outside;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_mem[ptr_cur[AW-1:0]] <= r_cur.pixel;
        end
        if (r_state == S_READ) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    assign o_valid = r_out_valid;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_item_valid)
        else $error("pop without a queued item");

    a_result_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_READ, 2))
        else $error("result raised without a read");

    a_fill_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill |-> (!r_out_valid || !i_stall))
        else $error("result would overwrite a pending one");

endmodule

`default_nettype wire

[sv/crop_and_scale_pixel_reader_core.sv]
//  channel   | direction | handshake                 | payload
//  input     | in        | i_valid / o_stall         | i_mode, i_blue_in, i_green_in, i_red_in,
//            |           |                           | i_dest_row, i_dest_col
//  output    | out       | o_valid / i_stall         | o_blue_out, o_green_out, o_red_out, o_outside
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The back-end sequencer handles one transaction at a time: a load passes fetch and store write,
// a read passes fetch, both multiplies, range check, address multiply and store read, and its
// result passes from the store read through the read data register into the output register.
// A four-entry queue in front keeps taking transactions while the back end works, until it is full.
// Reset is synchronous and clears control state only; the frame store is not cleared.
// A stalled result sits in the output register; the next read waits before its store read.
`default_nettype none

module crop_and_scale_pixel_reader_core #(
    parameter int MAX_SIDE = scpr_pkg::DEFAULT_MAX_SIDE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [11:0] i_dest_row,
    input  wire logic [11:0] i_dest_col,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_red_out,
    output logic             o_outside,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [scpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [scpr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import scpr_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int EW = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W;

    logic [SIDE_CFG_W-1:0] r_source_width, r_source_height;
    logic [STEP_W-1:0]     r_row_step, r_col_step;
    logic [OFF_W-1:0]      r_row_offset, r_col_offset;
    logic [SW-1:0]         w_eff, h_eff;
    logic                  cfg_wr;
    t_item                 item;
    logic                  item_valid;
    logic                  pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= RST_SIDE;
            r_source_height <= RST_SIDE;
            r_row_step      <= RST_STEP;
            r_col_step      <= RST_STEP;
            r_row_offset    <= RST_OFFSET;
            r_col_offset    <= RST_OFFSET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg_data[SIDE_CFG_W-1:0];
                CFG_SOURCE_HEIGHT: r_source_height <= i_cfg_data[SIDE_CFG_W-1:0];
                CFG_ROW_STEP:      r_row_step      <= i_cfg_data[STEP_W-1:0];
                CFG_COL_STEP:      r_col_step      <= i_cfg_data[STEP_W-1:0];
                CFG_ROW_OFFSET:    r_row_offset    <= i_cfg_data[OFF_W-1:0];
                CFG_COL_OFFSET:    r_col_offset    <= i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero counts as one, anything above MAX_SIDE clamps to it
    always_comb begin
        if (r_source_width == '0) begin
            w_eff = SW'(1);
        end else if (EW'(r_source_width) > EW'(MAX_SIDE)) begin
            w_eff = SW'(MAX_SIDE);
        end else begin
            w_eff = SW'(r_source_width);
        end
        if (r_source_height == '0) begin
            h_eff = SW'(1);
        end else if (EW'(r_source_height) > EW'(MAX_SIDE)) begin
            h_eff = SW'(MAX_SIDE);
        end else begin
            h_eff = SW'(r_source_height);
        end
    end

    scpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_blue_in    (i_blue_in),
        .i_green_in   (i_green_in),
        .i_red_in     (i_red_in),
        .i_dest_row   (i_dest_row),
        .i_dest_col   (i_dest_col),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_pop        (pop)
    );

    scpr_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_pop        (pop),
        .i_w_eff      (w_eff),
        .i_h_eff      (h_eff),
        .i_row_step   (r_row_step),
        .i_col_step   (r_col_step),
        .i_row_offset (r_row_offset),
        .i_col_offset (r_col_offset),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_blue_out   (o_blue_out),
        .o_green_out  (o_green_out),
        .o_red_out    (o_red_out),
        .o_outside    (o_outside)
    );

endmodule

`default_nettype wire
